// File: rtl/hr_pkg.sv
`timescale 1ns / 1ps

package hr_pkg;

    localparam int NOW_W       = 32;
    localparam int RATE_W      = 16;
    localparam int IVL_W       = 23;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int US_W        = 26;
    localparam int RECIP_W     = 29;
    localparam int PROD_W      = NOW_W + RECIP_W;
    localparam int QUO_W       = 16;
    localparam int DIV_CNT_W   = 4;
    localparam int BLEND_W     = RATE_W + 2;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    localparam logic [9:0]         US_PER_MS   = 10'd1000;
    localparam logic [QUO_W-1:0]   MS_PER_MIN  = 16'd60000;
    // ceil(2^38 / 1000): exact floor(x / 1000) for every 32-bit x
    localparam logic [RECIP_W-1:0] RECIP_MS    = 29'd274877907;
    localparam int                 RECIP_SHIFT = 38;

    localparam logic [US_W-1:0] REFR_US_RST = 26'd300000;
    localparam logic [US_W-1:0] TMO_US_RST  = 26'd3000000;

    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 8'd1;

    typedef struct packed {
        logic load_in;
        logic set_base;
        logic take_edge;
        logic scale;
        logic load_ivl;
        logic div_start;
        logic div_step;
        logic upd_rate;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic edge_req;
        logic first;
        logic pass;
        logic ivl_zero;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/hr_ctrl.sv
`timescale 1ns / 1ps

module hr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hr_pkg::t_sts  i_sts,
    output hr_pkg::t_cmd  o_cmd
);
    import hr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EVAL  = 7'b0000010,
        S_SCALE = 7'b0000100,
        S_MSEC  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_RATE  = 7'b0100000,
        S_PRES  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_sts.edge_req) begin
                    n_state = S_PRES;
                end else if (i_sts.first) begin
                    // no stored edge yet: this one only sets the baseline
                    o_cmd.set_base = 1'b1;
                    n_state        = S_PRES;
                end else if (i_sts.pass) begin
                    o_cmd.take_edge = 1'b1;
                    n_state         = S_SCALE;
                end else begin
                    n_state = S_PRES;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_MSEC;
            end
            S_MSEC: begin
                o_cmd.load_ivl = 1'b1;
                if (i_sts.ivl_zero) begin
                    n_state = S_PRES;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                o_cmd.upd_rate = 1'b1;
                n_state        = S_PRES;
            end
            S_PRES: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/hr_dp.sv
`timescale 1ns / 1ps

module hr_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hr_pkg::t_cmd                   i_cmd,
    output hr_pkg::t_sts                   o_sts,
    input  logic [hr_pkg::IN_TDATA_W-1:0]  i_in_tdata,
    input  logic [hr_pkg::IN_TUSER_W-1:0]  i_in_tuser,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [hr_pkg::OUT_TDATA_W-1:0] o_out_tdata,
    output logic [hr_pkg::OUT_TUSER_W-1:0] o_out_tuser,
    input  logic                           i_cfg_valid,
    input  logic [hr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hr_pkg::CFG_W-1:0]       i_cfg_data
);
    import hr_pkg::*;

    // state kept across items
    logic [NOW_W-1:0]  r_last_edge;
    logic [NOW_W-1:0]  r_last_beat;
    logic              r_beat_seen;
    logic [RATE_W-1:0] r_smooth;
    logic [IVL_W-1:0]  r_last_ivl;
    logic [US_W-1:0]   r_refr_us;
    logic [US_W-1:0]   r_tmo_us;
    logic              r_out_valid;

    // per-item work registers
    logic [NOW_W-1:0]       r_now;
    logic                   r_edge;
    logic                   r_beat;
    logic [NOW_W-1:0]       r_since;
    logic [PROD_W-1:0]      r_prod;
    logic [IVL_W-1:0]       r_rem;
    logic [QUO_W-1:0]       r_quo;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [OUT_TDATA_W-1:0] r_out_tdata;
    logic [OUT_TUSER_W-1:0] r_out_tuser;

    logic [NOW_W-1:0]   since;
    logic [NOW_W-1:0]   since_beat;
    logic [IVL_W-1:0]   ivl;
    logic [IVL_W:0]     rem_sh;
    logic [IVL_W:0]     rem_dif;
    logic               rem_ge;
    logic [BLEND_W-1:0] blend;
    logic               present;

    assign since      = r_now - r_last_edge;
    assign since_beat = r_now - r_last_beat;
    assign ivl        = r_prod[RECIP_SHIFT +: IVL_W];

    // one restoring step of 60000 / interval
    assign rem_sh  = {r_rem, r_quo[QUO_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_last_ivl});
    assign rem_dif = rem_sh - {1'b0, r_last_ivl};

    // (3 * old + new) / 4
    assign blend = ({2'b00, r_smooth} << 1) + {2'b00, r_smooth} + {2'b00, r_quo};

    // floor(elapsed / 1000) < timeout  <=>  elapsed < timeout * 1000
    assign present = r_beat_seen && (since_beat < {{(NOW_W-US_W){1'b0}}, r_tmo_us});

    assign o_sts.edge_req = r_edge;
    assign o_sts.first    = (r_last_edge == '0);
    assign o_sts.pass     = (since >= {{(NOW_W-US_W){1'b0}}, r_refr_us});
    assign o_sts.ivl_zero = (ivl == '0);
    assign o_sts.div_last = (r_cnt == {DIV_CNT_W{1'b1}});
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = r_out_tdata;
    assign o_out_tuser = r_out_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge <= '0;
            r_last_beat <= '0;
            r_beat_seen <= 1'b0;
            r_smooth    <= '0;
            r_last_ivl  <= '0;
            r_refr_us   <= REFR_US_RST;
            r_tmo_us    <= TMO_US_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_REFRACTORY: r_refr_us <= US_W'(i_cfg_data) * US_W'(US_PER_MS);
                    REG_TIMEOUT:    r_tmo_us  <= US_W'(i_cfg_data) * US_W'(US_PER_MS);
                    default: begin
                    end
                endcase
            end
            if (i_cmd.set_base) begin
                r_last_edge <= r_now;
            end
            if (i_cmd.take_edge) begin
                r_last_edge <= r_now;
                r_last_beat <= r_now;
                r_beat_seen <= 1'b1;
            end
            if (i_cmd.load_ivl) begin
                r_last_ivl <= ivl;
            end
            if (i_cmd.upd_rate) begin
                if (r_smooth == '0) begin
                    r_smooth <= r_quo;
                end else begin
                    r_smooth <= blend[BLEND_W-1:2];
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now  <= i_in_tdata[NOW_W-1:0];
            r_edge <= i_in_tuser[0];
        end
        if (i_cmd.load_in) begin
            r_beat <= 1'b0;
        end else if (i_cmd.upd_rate) begin
            r_beat <= 1'b1;
        end
        if (i_cmd.take_edge) begin
            r_since <= since;
        end
        if (i_cmd.scale) begin
            r_prod <= PROD_W'(r_since) * PROD_W'(RECIP_MS);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= MS_PER_MIN;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_dif[IVL_W-1:0] : rem_sh[IVL_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], rem_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_tdata <= {1'b0, r_last_ivl, r_smooth};
            r_out_tuser <= {present, r_beat};
        end
    end

endmodule

// File: rtl/heart_rate_from_beat_edges_top.sv
`timescale 1ns / 1ps

// Heart rate from pulse edges. Each input item is a microsecond time stamp with a flag
// for a falling pulse edge; each item returns exactly one result with the beat flag,
// the smoothed rate in bpm, the last inter-beat interval in ms and signal presence.
// One item is handled at a time: a sample or a rejected edge goes through evaluation
// to the result, an edge less than one ms after the stored one also through scaling
// and ms conversion, and a counted beat further through the bit-serial divider, which
// forms 60000 / interval one quotient bit per cycle, and the rate update. The next item
// is accepted as soon as the result sits in the output register, even before it is
// taken; a result that finds the output register still full waits until that one is
// taken. Configuration writes are taken in any cycle and are meant for idle periods.
module heart_rate_from_beat_edges_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] now_us
    input  logic [hr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] edge_req
    input  logic [hr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] rate_bpm, [38:16] interval_ms, [39] zero
    output logic [hr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] beat, [1] signal_present
    output logic [hr_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hr_pkg::CFG_W-1:0]       i_cfg_data
);
    import hr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    hr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// File: rtl/hr_chk.sv
`timescale 1ns / 1ps

module hr_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [hr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [hr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [hr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [hr_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [hr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [hr_pkg::CFG_W-1:0]       i_cfg_data
);
    import hr_pkg::*;

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // one request in work at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // a counted beat never has a zero ms interval
    a_beat_ivl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[38:16] != '0)
        else $error("beat with zero interval");

endmodule

bind heart_rate_from_beat_edges_top hr_chk u_hr_chk (.*);
